// ----- sv/rchsv_pkg.sv -----
// Shared constants, types and helper functions for the rainbow chase pixel unit.
package rchsv_pkg;

  localparam int PIXEL_COUNT = 10;
  localparam int CNT_W       = $clog2(PIXEL_COUNT + 1);
  localparam int IDX_W       = 4;
  localparam int COLOR_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SATURATION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_SPACING = 2'd2;

  localparam logic [COLOR_W-1:0] SAT_RESET     = 8'd255;
  localparam logic [COLOR_W-1:0] BRIGHT_RESET  = 8'd255;
  localparam logic [COLOR_W-1:0] SPACING_RESET = 8'd2;
  localparam logic [COLOR_W-1:0] FRAME_RESET   = 8'd1;

  localparam logic [CNT_W-1:0] LIMIT_MAX  = CNT_W'(PIXEL_COUNT);
  localparam logic [CNT_W-1:0] LAST_INDEX = CNT_W'(PIXEL_COUNT - 1);

  localparam logic [2:0] REGION_0 = 3'd0;
  localparam logic [2:0] REGION_1 = 3'd1;
  localparam logic [2:0] REGION_2 = 3'd2;
  localparam logic [2:0] REGION_3 = 3'd3;
  localparam logic [2:0] REGION_4 = 3'd4;
  localparam logic [2:0] REGION_5 = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic start;   // load hue accumulator and pixel counter for a new frame
    logic issue;   // push the current pixel into the conversion pipeline
  } rchsv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic adv;      // pipeline moves this cycle
    logic at_last;  // pixel counter sits on the final pixel
  } rchsv_sts_t;

  // hue / 43 for an 8-bit hue
  function automatic logic [2:0] region_of(input logic [COLOR_W-1:0] h);
    logic [2:0] r;
    if (h < 8'd43)       r = REGION_0;
    else if (h < 8'd86)  r = REGION_1;
    else if (h < 8'd129) r = REGION_2;
    else if (h < 8'd172) r = REGION_3;
    else if (h < 8'd215) r = REGION_4;
    else                 r = REGION_5;
    return r;
  endfunction

  // region * 43
  function automatic logic [COLOR_W-1:0] region_base(input logic [2:0] r);
    logic [COLOR_W-1:0] b;
    unique case (r)
      REGION_0: b = 8'd0;
      REGION_1: b = 8'd43;
      REGION_2: b = 8'd86;
      REGION_3: b = 8'd129;
      REGION_4: b = 8'd172;
      default:  b = 8'd215;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/rainbow_chase_hsv_pixels_unit.sv -----
// Rainbow chase pixel unit: one frame request in, one RGB beat per strip pixel out.
// Each accepted beat with frame_request set starts a frame; the unit then issues
// PIXEL_COUNT pixels into a single conversion pipeline at one pixel per cycle
// whenever the pipeline advances, and the next request is taken right after the
// last pixel is issued. Results pass through three conversion stages and an
// output register, and the pipeline stalls whenever the output beat is not taken.
// A request beat with frame_request clear is taken and produces nothing.
// Configuration writes belong to idle periods, with all earlier pixels delivered.
module rainbow_chase_hsv_pixels_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [rchsv_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [0] frame_request
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [3:0] pixel_index, [11:4] red, [19:12] green, [27:20] blue, [31:28] zero
  output logic [rchsv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                  m_axis_tlast,  // last_pixel
  input  logic                                  cfg_we,
  input  logic [rchsv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rchsv_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rchsv_pkg::*;

  rchsv_cmd_t         cmd;
  rchsv_sts_t         sts;
  logic [IDX_W-1:0]   pix_index;
  logic [COLOR_W-1:0] pix_red;
  logic [COLOR_W-1:0] pix_green;
  logic [COLOR_W-1:0] pix_blue;

  rchsv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_bit   (s_axis_tdata[0]),
    .req_ready (s_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rchsv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_index (pix_index),
    .out_red   (pix_red),
    .out_green (pix_green),
    .out_blue  (pix_blue),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, pix_blue, pix_green, pix_red, pix_index};

endmodule

// ----- sv/rchsv_ctrl.sv -----
// Frame sequencer: accepts frame requests and issues one pixel per pipeline advance.
module rchsv_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  logic                    req_bit,
  output logic                    req_ready,
  input  rchsv_pkg::rchsv_sts_t   sts,
  output rchsv_pkg::rchsv_cmd_t   cmd
);
  import rchsv_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    cmd.start  = 1'b0;
    cmd.issue  = 1'b0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        // a request bit of zero is taken and dropped
        if (req_valid && req_bit) begin
          cmd.start  = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = sts.adv;
        if (sts.adv && sts.at_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/rchsv_dp.sv -----
// Datapath: config registers, chase state, hue stepping and the HSV-to-RGB pipeline.
module rchsv_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rchsv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rchsv_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  rchsv_pkg::rchsv_cmd_t               cmd,
  output rchsv_pkg::rchsv_sts_t               sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rchsv_pkg::IDX_W-1:0]         out_index,
  output logic [rchsv_pkg::COLOR_W-1:0]       out_red,
  output logic [rchsv_pkg::COLOR_W-1:0]       out_green,
  output logic [rchsv_pkg::COLOR_W-1:0]       out_blue,
  output logic                                out_last
);
  import rchsv_pkg::*;

  logic [COLOR_W-1:0] saturation;
  logic [COLOR_W-1:0] brightness;
  logic [COLOR_W-1:0] hue_spacing;
  logic [COLOR_W-1:0] frame_count;
  logic [CNT_W-1:0]   lit_limit;
  logic               growing;
  logic [CNT_W-1:0]   lit_limit_next;
  logic               growing_next;

  logic [COLOR_W-1:0] hue_acc;
  logic [CNT_W-1:0]   cnt;

  logic adv;

  // stage 1: hue and pixel tags
  logic               v1;
  logic [COLOR_W-1:0] hue1;
  logic [CNT_W-1:0]   idx1;
  logic               last1;
  logic               dark1;
  // stage 2: region and scaled fraction
  logic               v2;
  logic [2:0]         region2;
  logic [COLOR_W-1:0] frac2;
  logic [CNT_W-1:0]   idx2;
  logic               last2;
  logic               dark2;
  // stage 3: first products
  logic               v3;
  logic [2:0]         region3;
  logic [COLOR_W-1:0] sf3;
  logic [COLOR_W-1:0] sg3;
  logic [COLOR_W-1:0] p3;
  logic [CNT_W-1:0]   idx3;
  logic               last3;
  logic               dark3;

  logic [COLOR_W-1:0] diff1;
  logic [2:0]         region1;
  logic [COLOR_W-1:0] frac1;
  logic [15:0]        sf_prod;
  logic [15:0]        sg_prod;
  logic [15:0]        p_prod;
  logic [15:0]        q_prod;
  logic [15:0]        t_prod;
  logic [COLOR_W-1:0] q4;
  logic [COLOR_W-1:0] t4;
  logic [COLOR_W-1:0] r4;
  logic [COLOR_W-1:0] g4;
  logic [COLOR_W-1:0] b4;

  assign adv         = !out_valid || out_ready;
  assign sts.adv     = adv;
  assign sts.at_last = (cnt == LAST_INDEX);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      saturation  <= SAT_RESET;
      brightness  <= BRIGHT_RESET;
      hue_spacing <= SPACING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SATURATION:  saturation  <= cfg_data;
        REG_BRIGHTNESS:  brightness  <= cfg_data;
        REG_HUE_SPACING: hue_spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  // bounce the lit limit between 0 and the pixel count
  always_comb begin
    lit_limit_next = lit_limit;
    growing_next   = growing;
    if (growing) begin
      if (lit_limit < LIMIT_MAX) lit_limit_next = lit_limit + 1'b1;
      if (lit_limit_next >= LIMIT_MAX) growing_next = 1'b0;
    end else begin
      if (lit_limit != '0) lit_limit_next = lit_limit - 1'b1;
      if (lit_limit_next == '0) growing_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_RESET;
      lit_limit   <= LIMIT_MAX;
      growing     <= 1'b0;
    end else if (cmd.issue && sts.at_last) begin
      frame_count <= frame_count + 1'b1;
      lit_limit   <= lit_limit_next;
      growing     <= growing_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hue_acc <= frame_count;
      cnt     <= '0;
    end else if (cmd.issue) begin
      hue_acc <= hue_acc + hue_spacing;
      cnt     <= cnt + 1'b1;
    end
  end

  // stage 2 logic
  assign region1 = region_of(hue1);
  assign diff1   = hue1 - region_base(region1);
  assign frac1   = (diff1 << 2) + (diff1 << 1);

  // stage 3 logic
  assign sf_prod = {8'd0, saturation} * {8'd0, frac2};
  assign sg_prod = {8'd0, saturation} * {8'd0, 8'd255 - frac2};
  assign p_prod  = {8'd0, brightness} * {8'd0, 8'd255 - saturation};

  // output stage logic
  assign q_prod = {8'd0, brightness} * {8'd0, 8'd255 - sf3};
  assign t_prod = {8'd0, brightness} * {8'd0, 8'd255 - sg3};
  assign q4     = q_prod[15:8];
  assign t4     = t_prod[15:8];

  always_comb begin
    unique case (region3)
      REGION_0: begin r4 = brightness; g4 = t4;         b4 = p3;         end
      REGION_1: begin r4 = q4;         g4 = brightness; b4 = p3;         end
      REGION_2: begin r4 = p3;         g4 = brightness; b4 = t4;         end
      REGION_3: begin r4 = p3;         g4 = q4;         b4 = brightness; end
      REGION_4: begin r4 = t4;         g4 = p3;         b4 = brightness; end
      default:  begin r4 = brightness; g4 = p3;         b4 = q4;         end
    endcase
    // zero saturation is plain grey
    if (saturation == '0) begin
      r4 = brightness;
      g4 = brightness;
      b4 = brightness;
    end
    if (dark3) begin
      r4 = '0;
      g4 = '0;
      b4 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= cmd.issue;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue1    <= hue_acc;
      idx1    <= cnt;
      last1   <= (cnt == LAST_INDEX);
      dark1   <= (cnt > lit_limit);

      region2 <= region1;
      frac2   <= frac1;
      idx2    <= idx1;
      last2   <= last1;
      dark2   <= dark1;

      region3 <= region2;
      sf3     <= sf_prod[15:8];
      sg3     <= sg_prod[15:8];
      p3      <= p_prod[15:8];
      idx3    <= idx2;
      last3   <= last2;
      dark3   <= dark2;

      out_index <= IDX_W'(idx3);
      out_red   <= r4;
      out_green <= g4;
      out_blue  <= b4;
      out_last  <= last3;
    end
  end

endmodule

// ----- sv/rchsv_chk.sv -----
// Port-level checks for the rainbow chase pixel unit, bound to the top level.
module rchsv_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic [rchsv_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [rchsv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input logic                                 m_axis_tlast
);
  import rchsv_pkg::*;

  // the frame mark sits only on the final strip position
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[IDX_W-1:0] == IDX_W'(PIXEL_COUNT - 1))
    else $error("tlast on a pixel other than the final one");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // a frame request blocks further requests while its pixels are issued
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[0] |=> !s_axis_tready)
    else $error("request taken while a frame is being issued");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind rainbow_chase_hsv_pixels_unit rchsv_chk u_rchsv_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- bench/rchsv_checker.sv -----
// Scoreboard for the rainbow chase pixel unit: predicts every pixel beat and compares it.
`timescale 1ns / 100ps

module rchsv_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  input  logic                                  s_axis_tready,
  input  logic [rchsv_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [0] frame_request
  input  logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [3:0] pixel_index, [11:4] red, [19:12] green, [27:20] blue
  input  logic [rchsv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                  m_axis_tlast,   // last_pixel
  input  logic                                  cfg_we,
  input  logic [rchsv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rchsv_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                    mismatches,
  output int                                    outstanding
);

  import rchsv_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } pixel_t;

  pixel_t pixel_queue[$];

  logic [COLOR_W-1:0] saturation_q;
  logic [COLOR_W-1:0] brightness_q;
  logic [COLOR_W-1:0] spacing_q;
  logic [COLOR_W-1:0] frame_q;
  logic [CNT_W-1:0]   limit_q;
  logic               growing_q;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic void hsv_to_rgb(input int unsigned h, input int unsigned s,
                                     input int unsigned v, output logic [COLOR_W-1:0] r,
                                     output logic [COLOR_W-1:0] g,
                                     output logic [COLOR_W-1:0] b);
    int unsigned region, frac, p, q, t;
    logic [2:0]  sector;
    if (s == 0) begin
      // grey: every channel carries the brightness
      r = v[7:0];
      g = v[7:0];
      b = v[7:0];
      return;
    end
    region = h / 43;
    frac   = (h - region * 43) * 6;
    p      = (v * (255 - s)) >> 8;
    q      = (v * (255 - ((s * frac) >> 8))) >> 8;
    t      = (v * (255 - ((s * (255 - frac)) >> 8))) >> 8;
    sector = region[2:0];
    case (sector)
      REGION_0: begin r = v[7:0]; g = t[7:0]; b = p[7:0]; end
      REGION_1: begin r = q[7:0]; g = v[7:0]; b = p[7:0]; end
      REGION_2: begin r = p[7:0]; g = v[7:0]; b = t[7:0]; end
      REGION_3: begin r = p[7:0]; g = q[7:0]; b = v[7:0]; end
      REGION_4: begin r = t[7:0]; g = p[7:0]; b = v[7:0]; end
      default:  begin r = v[7:0]; g = p[7:0]; b = q[7:0]; end
    endcase
  endfunction

  // queue one frame of pixels, then advance the counter and bounce the lit limit
  function automatic void predict_frame();
    int unsigned        i;
    logic [COLOR_W-1:0] hue;
    pixel_t             px;
    for (i = 0; i < PIXEL_COUNT; i++) begin
      hue = 8'(frame_q + i * spacing_q);
      hsv_to_rgb(hue, saturation_q, brightness_q, px.red, px.green, px.blue);
      if (i > limit_q) begin
        px.red   = '0;
        px.green = '0;
        px.blue  = '0;
      end
      px.index = i[IDX_W-1:0];
      px.last  = (i == PIXEL_COUNT - 1);
      pixel_queue.push_back(px);
    end
    frame_q = frame_q + 8'd1;
    if (growing_q) begin
      if (limit_q < LIMIT_MAX) limit_q = limit_q + 1'b1;
      if (limit_q >= LIMIT_MAX) growing_q = 1'b0;
    end else begin
      if (limit_q > 0) limit_q = limit_q - 1'b1;
      if (limit_q == 0) growing_q = 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    pixel_t got;
    pixel_t want;
    if (rst) begin
      saturation_q = SAT_RESET;
      brightness_q = BRIGHT_RESET;
      spacing_q    = SPACING_RESET;
      frame_q      = FRAME_RESET;
      limit_q      = LIMIT_MAX;
      growing_q    = 1'b0;
      pixel_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SATURATION:  saturation_q = cfg_data;
          REG_BRIGHTNESS:  brightness_q = cfg_data;
          REG_HUE_SPACING: spacing_q    = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready && s_axis_tdata[0]) predict_frame();
      if (m_axis_tvalid && m_axis_tready) begin
        got.index = m_axis_tdata[3:0];
        got.red   = m_axis_tdata[11:4];
        got.green = m_axis_tdata[19:12];
        got.blue  = m_axis_tdata[27:20];
        got.last  = m_axis_tlast;
        if (pixel_queue.size() == 0) begin
          $error("pixel beat with nothing pending: index %0d", got.index);
          mismatches++;
        end else begin
          want = pixel_queue.pop_front();
          check_field("pixel_index", want.index, got.index);
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("last_pixel", want.last, got.last);
        end
      end
    end
    outstanding <= pixel_queue.size();
  end

endmodule

// ----- bench/tb_rainbow_chase_hsv_pixels_unit.sv -----
// Stimulus and verdict for the rainbow chase pixel unit.
`timescale 1ns / 100ps

module tb_rainbow_chase_hsv_pixels_unit;

  import rchsv_pkg::*;

  logic                    clk;
  logic                    rst;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata;   // [0] frame_request
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // [3:0] index, [11:4] r, [19:12] g, [27:20] b
  logic                    m_axis_tlast;   // last_pixel
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    steady = 1'b0;
  int                      mismatches;
  int                      outstanding;

  rainbow_chase_hsv_pixels_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  rchsv_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sink side: stall at random unless in the steady stretch
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 38);
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // one frame request beat; valid stays high into the next beat unless we idle
  task automatic send_request(input logic req);
    while (!steady && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, req};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // drop valid and hold until every pixel beat is back, then let the pipe go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] sat, input logic [7:0] bright,
                            input logic [7:0] spacing);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SATURATION;
    cfg_data  <= sat;
    @(posedge clk);
    cfg_index <= REG_BRIGHTNESS;
    cfg_data  <= bright;
    @(posedge clk);
    cfg_index <= REG_HUE_SPACING;
    cfg_data  <= spacing;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int   frames;
    int   next_reconfig;
    logic req;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset-like settings, shrinking limit, and an idle request in between
    set_config(8'd255, 8'd255, 8'd2);
    repeat (3) send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    settle();
    // zero saturation gives grey
    set_config(8'd0, 8'd200, 8'd255);
    repeat (3) send_request(1'b1);
    settle();
    // black at zero brightness, one hue across the strip
    set_config(8'd255, 8'd0, 8'd0);
    repeat (2) send_request(1'b1);
    settle();
    // region steps and minimum saturation
    set_config(8'd1, 8'd255, 8'd43);
    repeat (3) send_request(1'b1);
    settle();
    set_config(8'd128, 8'd128, 8'd1);
    repeat (3) send_request(1'b1);
    send_request(1'b0);
    settle();
    set_config(8'd255, 8'd255, 8'd128);
    repeat (2) send_request(1'b1);
    settle();

    frames        = 0;
    next_reconfig = 0;
    while (frames < 120) begin
      if (frames >= next_reconfig) begin
        settle();
        set_config(pick_value(), pick_value(), pick_value());
        next_reconfig = frames + 25;
      end
      steady <= (frames >= 60 && frames < 95);
      req = ($urandom_range(0, 9) != 0);
      send_request(req);
      if (req) frames++;
    end
    settle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
